// File: design/rpmp_pkg.sv
// Shared types and constants for the row prefix max pool unit.
// No dependencies.
package rpmp_pkg;

   localparam int POS_W      = 10;
   localparam int VAL_W      = 24;
   localparam int SAMPLE_W   = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic signed [VAL_W-1:0] GSUM_MAX = 24'sh7FFFFF;
   localparam logic signed [VAL_W-1:0] GSUM_MIN = 24'sh800000;

   typedef enum logic {
      MODE_FORWARD  = 1'b0,
      MODE_BACKWARD = 1'b1
   } mode_type;

   typedef struct packed {
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      logic                    run_last;
      logic                    row_done;
   } rsp_item_type;

   // One queue entry: one or two results caused by a single input item.
   typedef struct packed {
      logic         two;
      rsp_item_type first;
      rsp_item_type second;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// File: design/rpmp_front.sv
// Front end: accepts row elements, keeps the running max / argmax state and
// builds result jobs. Depends on rpmp_pkg.
module rpmp_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_mode,
   output logic                  csr_ready,
   input  logic                  accept,
   input  logic signed [15:0]    sample,
   input  logic signed [15:0]    grad,
   input  logic                  row_last,
   output logic                  job_valid,
   output rpmp_pkg::job_type     job
);
   import rpmp_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [COL_W-1:0] COL_TOP = COL_W'(MAX_WIDTH - 1);

   mode_type                    mode_ff, mode_in;
   logic signed [SAMPLE_W-1:0]  max_ff, max_in;
   logic [COL_W-1:0]            maxpos_ff, maxpos_in;
   logic signed [VAL_W-1:0]     gsum_ff, gsum_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic                        start_ff, start_in;

   logic                        moved;
   logic signed [VAL_W:0]       sum;
   logic signed [VAL_W-1:0]     sat;
   logic [COL_W+POS_W-1:0]      col_ext, maxpos_ext, oldpos_ext;
   rsp_item_type                move_item, end_item;

   assign csr_ready = 1'b1;

   always_comb begin
      sum = {gsum_ff[VAL_W-1], gsum_ff} + (VAL_W+1)'(grad);
      if (sum[VAL_W] != sum[VAL_W-1]) begin
         sat = sum[VAL_W] ? GSUM_MIN : GSUM_MAX;
      end else begin
         sat = sum[VAL_W-1:0];
      end
   end

   always_comb begin
      moved     = 1'b0;
      col_in    = col_ff;
      max_in    = max_ff;
      maxpos_in = maxpos_ff;
      gsum_in   = gsum_ff;
      if (start_ff) begin
         col_in    = '0;
         max_in    = sample;
         maxpos_in = '0;
         gsum_in   = VAL_W'(grad);
      end else begin
         if (col_ff < COL_TOP) begin
            col_in = col_ff + 1'b1;
         end
         if (sample > max_ff) begin
            moved     = 1'b1;
            max_in    = sample;
            maxpos_in = col_in;
            gsum_in   = VAL_W'(grad);
         end else begin
            gsum_in = sat;
         end
      end
   end

   assign col_ext    = {{POS_W{1'b0}}, col_in};
   assign maxpos_ext = {{POS_W{1'b0}}, maxpos_in};
   assign oldpos_ext = {{POS_W{1'b0}}, maxpos_ff};

   always_comb begin
      move_item.position = oldpos_ext[POS_W-1:0];
      move_item.value    = gsum_ff;
      move_item.run_last = ~row_last;
      move_item.row_done = 1'b0;

      end_item.position  = maxpos_ext[POS_W-1:0];
      end_item.value     = gsum_in;
      end_item.run_last  = 1'b1;
      end_item.row_done  = 1'b1;

      job.two    = 1'b0;
      job.first  = end_item;
      job.second = end_item;
      job_valid  = 1'b0;
      if (mode_ff == MODE_FORWARD) begin
         job.first.position = col_ext[POS_W-1:0];
         job.first.value    = VAL_W'(max_in);
         job.first.row_done = row_last;
         job_valid          = accept;
      end else if (moved) begin
         job.first = move_item;
         job.two   = row_last;
         job_valid = accept;
      end else begin
         job_valid = accept & row_last;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid) begin
         mode_in = mode_type'(csr_mode);
      end
      start_in = accept ? row_last : start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FORWARD;
         start_ff  <= 1'b1;
         max_ff    <= '0;
         maxpos_ff <= '0;
         gsum_ff   <= '0;
         col_ff    <= '0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         if (accept) begin
            max_ff    <= max_in;
            maxpos_ff <= maxpos_in;
            gsum_ff   <= gsum_in;
            col_ff    <= col_in;
         end
      end
   end

endmodule

// File: design/rpmp_queue.sv
// Short job queue between front and back ends, flip-flop storage.
// Depends on rpmp_pkg.
module rpmp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  rpmp_pkg::job_type          wr_data,
   input  logic                       rd_en,
   output rpmp_pkg::job_type          rd_data,
   output rpmp_pkg::queue_status_type status
);
   import rpmp_pkg::*;

   job_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wptr_ff, wptr_in;
   logic [QUEUE_PTR_W-1:0]  rptr_ff, rptr_in;
   logic [QUEUE_PTR_W:0]    count_ff, count_in;
   logic                    do_wr, do_rd;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign do_wr   = wr_en & ~status.full;
   assign do_rd   = rd_en & ~status.empty;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

// File: design/rpmp_back.sv
// Back end: splits queued jobs into single results and drives the result
// output register. Depends on rpmp_pkg.
module rpmp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rpmp_pkg::job_type          head,
   input  rpmp_pkg::queue_status_type q_status,
   output logic                       q_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [9:0]                 rsp_position,
   output logic signed [23:0]         rsp_value,
   output logic                       rsp_run_last,
   output logic                       rsp_row_done
);
   import rpmp_pkg::*;

   logic         valid_ff, valid_in;
   logic         phase_ff, phase_in;
   rsp_item_type item_ff, item_in;
   logic         load;

   assign load = ~valid_ff | rsp_pop;

   always_comb begin
      valid_in = valid_ff & ~rsp_pop;
      phase_in = phase_ff;
      item_in  = item_ff;
      q_pop    = 1'b0;
      if (load && !q_status.empty) begin
         valid_in = 1'b1;
         if (head.two && !phase_ff) begin
            item_in  = head.first;
            phase_in = 1'b1;
         end else begin
            item_in  = phase_ff ? head.second : head.first;
            phase_in = 1'b0;
            q_pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      item_ff <= item_in;
   end

   assign rsp_empty    = ~valid_ff;
   assign rsp_position = item_ff.position;
   assign rsp_value    = item_ff.value;
   assign rsp_run_last = item_ff.run_last;
   assign rsp_row_done = item_ff.row_done;

endmodule

// File: design/row_prefix_max_pool_unit.sv
// Top level of the row prefix max pool (right corner pool) unit.
// Depends on rpmp_pkg, rpmp_front, rpmp_queue, rpmp_back.
//
// Row elements (Q8.8) enter one per cycle while req_full is low; the front end
// updates the running max / argmax state in the transfer cycle and queues the
// results that element causes in a 4-entry job queue. Forward mode (mode 0)
// gives one running-max result per element; backward mode (mode 1) gives sparse
// position/gradient-sum results when the argmax moves and at row end. The back
// end drains one result per cycle into the output register unless a held result
// waits for rsp_pop; results pass the job queue and the output register in turn,
// two results of one element leave in order; req_full rises at four queued jobs.
// csr_mode may be written only while the unit is idle; csr_ready is always high.
module row_prefix_max_pool_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_mode,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [15:0]  req_sample,
   input  logic signed [15:0]  req_grad,
   input  logic                req_row_last,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [9:0]          rsp_position,
   output logic signed [23:0]  rsp_value,
   output logic                rsp_run_last,
   output logic                rsp_row_done
);
   import rpmp_pkg::*;

   logic             accept;
   logic             job_valid;
   job_type          job;
   job_type          head;
   logic             q_pop;
   queue_status_type q_status;

   assign req_full = q_status.full;
   assign accept   = req_push & ~q_status.full;

   rpmp_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_mode  (csr_mode),
      .csr_ready (csr_ready),
      .accept    (accept),
      .sample    (req_sample),
      .grad      (req_grad),
      .row_last  (req_row_last),
      .job_valid (job_valid),
      .job       (job)
   );

   rpmp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_valid),
      .wr_data (job),
      .rd_en   (q_pop),
      .rd_data (head),
      .status  (q_status)
   );

   rpmp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_position (rsp_position),
      .rsp_value    (rsp_value),
      .rsp_run_last (rsp_run_last),
      .rsp_row_done (rsp_row_done)
   );

endmodule

// File: design/rpmp_checker.sv
// Port-level assertions for row_prefix_max_pool_unit, with bind.
// Depends on row_prefix_max_pool_unit.
module rpmp_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_full,
   input logic                rsp_empty,
   input logic                rsp_pop,
   input logic [9:0]          rsp_position,
   input logic signed [23:0]  rsp_value,
   input logic                rsp_run_last,
   input logic                rsp_row_done
);

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_position) && $stable(rsp_value)
          && $stable(rsp_run_last) && $stable(rsp_row_done)))
      else $error("stalled result changed");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_run_last) |=> !rsp_empty)
      else $error("second result of a run missing");

endmodule

bind row_prefix_max_pool_unit rpmp_checker u_rpmp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_position (rsp_position),
   .rsp_value    (rsp_value),
   .rsp_run_last (rsp_run_last),
   .rsp_row_done (rsp_row_done)
);

// File: sim/row_prefix_max_pool_unit_test.sv
// Self-checking testbench for row_prefix_max_pool_unit: queued row elements in
// bursts, results drained by a stalling monitor and checked against a predictor.
// Depends on rpmp_pkg and the row_prefix_max_pool_unit RTL.
`timescale 1ns / 1ps

module row_prefix_max_pool_unit_test;
   import rpmp_pkg::*;

   localparam int POOL_WIDTH     = 1024;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] grad;
      logic                       row_last;
   } row_element_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_mode = 1'b0;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic signed [15:0]        req_sample = '0;
   logic signed [15:0]        req_grad = '0;
   logic                      req_row_last = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [9:0]                rsp_position;
   logic signed [23:0]        rsp_value;
   logic                      rsp_run_last;
   logic                      rsp_row_done;

   row_prefix_max_pool_unit #(.MAX_WIDTH(POOL_WIDTH)) uut (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_mode     (csr_mode),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_sample   (req_sample),
      .req_grad     (req_grad),
      .req_row_last (req_row_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_position (rsp_position),
      .rsp_value    (rsp_value),
      .rsp_run_last (rsp_run_last),
      .rsp_row_done (rsp_row_done)
   );

   always #4 clock = ~clock;

   // predictor state
   mode_type                mode_q = MODE_FORWARD;
   logic signed [15:0]      max_q = '0;
   logic [POS_W-1:0]        argmax_q = '0;
   logic signed [VAL_W-1:0] gsum_q = '0;
   logic [POS_W-1:0]        col_q = '0;
   logic                    row_start_q = 1'b1;

   row_element_type pending_elements[$];
   rsp_item_type    pool_results_due[$];
   int              accepted_items = 0;
   int              mismatches = 0;

   task automatic push_result(input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val,
                              input logic rl, input logic rd);
      rsp_item_type r;
      r.position = pos;
      r.value    = val;
      r.run_last = rl;
      r.row_done = rd;
      pool_results_due.push_back(r);
   endtask

   task automatic pool_row_element(input logic signed [15:0] s, input logic signed [15:0] g,
                                   input logic last);
      logic signed [VAL_W:0] t;
      if (row_start_q) begin
         col_q    = '0;
         max_q    = s;
         argmax_q = '0;
         gsum_q   = {{(VAL_W-16){g[15]}}, g};
      end else begin
         if (int'(col_q) < POOL_WIDTH - 1)
            col_q = col_q + 1'b1;
         if (s > max_q) begin
            if (mode_q == MODE_BACKWARD)
               push_result(argmax_q, gsum_q, !last, 1'b0);
            max_q    = s;
            argmax_q = col_q;
            gsum_q   = {{(VAL_W-16){g[15]}}, g};
         end else begin
            t = {gsum_q[VAL_W-1], gsum_q} + {{(VAL_W-15){g[15]}}, g};
            if (t > GSUM_MAX)
               t = GSUM_MAX;
            if (t < GSUM_MIN)
               t = GSUM_MIN;
            gsum_q = t[VAL_W-1:0];
         end
      end
      if (mode_q == MODE_FORWARD)
         push_result(col_q, {{(VAL_W-16){max_q[15]}}, max_q}, 1'b1, last);
      else if (last)
         push_result(argmax_q, gsum_q, 1'b1, 1'b1);
      row_start_q = last;
   endtask

   // driver: bursts of transfers with random gaps
   row_element_type cur;
   int burst_left = 0;
   int gap_left = 0;
   logic offer;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            pool_row_element(cur.sample, cur.grad, cur.row_last);
            accepted_items++;
         end
         if (!req_push || !req_full) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_elements.size() != 0) begin
               cur   = pending_elements.pop_front();
               offer = 1'b1;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_push     <= offer;
            req_sample   <= cur.sample;
            req_grad     <= cur.grad;
            req_row_last <= cur.row_last;
         end
      end
   end

   // monitor: checks each result transfer, pops on a changing pattern
   int   hold_left = 0;
   int   hold_at = 400;
   int   pop_style = 0;
   int   style_left = 50;
   int   pattern_count = 0;
   logic pop_next;
   rsp_item_type want;

   task automatic check_field(input string name, input longint wanted, input longint got);
      if (wanted != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, wanted, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pool_results_due.size() == 0) begin
               $display("%0t: unexpected result position %0d value %0d", $time,
                        rsp_position, rsp_value);
               mismatches++;
            end else begin
               want = pool_results_due.pop_front();
               check_field("position", want.position, rsp_position);
               check_field("value", want.value, rsp_value);
               check_field("run_last", want.run_last, rsp_run_last);
               check_field("row_done", want.row_done, rsp_row_done);
            end
         end
         pattern_count++;
         if (hold_left == 0 && accepted_items >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at += 1100;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop_next = 1'b0;
         end else begin
            case (pop_style)
               0: pop_next = 1'b1;
               1: pop_next = $urandom_range(0, 1);
               2: pop_next = ($urandom_range(0, 7) == 0);
               default: pop_next = (pattern_count % 5) < 3;
            endcase
         end
         style_left--;
         if (style_left <= 0) begin
            pop_style  = $urandom_range(0, 3);
            style_left = $urandom_range(20, 120);
         end
         rsp_pop <= pop_next;
      end
   end

   // watchdog on cycles without any transfer
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic add_item(input logic signed [15:0] s, input logic signed [15:0] g,
                           input logic last);
      row_element_type e;
      e.sample   = s;
      e.grad     = g;
      e.row_last = last;
      pending_elements.push_back(e);
   endtask

   task automatic add_random_rows(input int n);
      int left, len, kind, v;
      logic signed [15:0] g;
      left = n;
      while (left > 0) begin
         kind = $urandom_range(0, 99);
         len  = $urandom_range(1, 12);
         if (len > left)
            len = left;
         v = $urandom_range(0, 32768) - 32768;
         for (int i = 0; i < len; i++) begin
            if (kind < 55) begin
               v = $urandom_range(0, 65535) - 32768;
            end else if (kind < 70) begin
               v = $urandom_range(0, 2) - 1;
            end else if (kind < 85) begin
               v = v + $urandom_range(1, 300);
               if (v > 32767)
                  v = 32767;
            end else begin
               v = v - $urandom_range(0, 300);
               if (v < -32768)
                  v = -32768;
            end
            if ($urandom_range(0, 9) < 3)
               g = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            else
               g = 16'($urandom);
            add_item(16'(v), g, i == len - 1);
         end
         left -= len;
      end
   endtask

   // one row: flat stretch saturating low, flat stretch saturating high,
   // then a rising tail that runs past the column limit
   task automatic add_long_row();
      logic signed [15:0] s, g;
      for (int i = 0; i < POOL_WIDTH + 16; i++) begin
         if (i < 280) begin
            s = 16'sh8000;
            g = 16'sh8000;
         end else if (i < 560) begin
            s = 16'sh8001;
            g = 16'sh7FFF;
         end else begin
            s = 16'(i - 600);
            g = 16'($urandom);
         end
         add_item(s, g, i == POOL_WIDTH + 15);
      end
   endtask

   task automatic settle();
      while (pending_elements.size() != 0 || req_push || pool_results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_mode  <= m;
      do
         @(posedge clock);
      while (!csr_ready);
      mode_q = m;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_FORWARD);
      add_item(16'sh8000, 16'sh1234, 1'b0);
      add_item(16'sh7FFF, 16'sh7FFF, 1'b0);
      add_item(16'sh0000, 16'sh8000, 1'b1);
      add_item(16'sh7FFF, 16'sh0000, 1'b1);
      add_item(-16'sd1, 16'sh00FF, 1'b0);
      add_item(-16'sd1, 16'shFF00, 1'b1);
      settle();

      write_mode(MODE_BACKWARD);
      add_item(16'sd5, 16'sh7FFF, 1'b1);
      add_item(16'sd10, 16'sd3, 1'b0);
      add_item(16'sd10, 16'sd4, 1'b0);
      add_item(16'sd9, -16'sd2, 1'b0);
      add_item(16'sd11, 16'sd7, 1'b0);
      add_item(16'sd20, 16'sh8000, 1'b1);
      add_item(16'sh8000, 16'sh8000, 1'b0);
      add_item(16'sh8000, 16'sh8000, 1'b0);
      add_item(16'sh7FFF, 16'sd1, 1'b1);
      add_item(16'sd100, 16'sd1, 1'b0);
      add_item(16'sd50, 16'sd2, 1'b0);
      settle();

      // row left open across the mode change
      write_mode(MODE_FORWARD);
      add_random_rows(150);
      add_item(16'($urandom), 16'($urandom), 1'b0);
      add_item(16'($urandom), 16'($urandom), 1'b0);
      settle();

      write_mode(MODE_BACKWARD);
      add_random_rows(100);
      add_long_row();
      add_random_rows(50);
      settle();

      write_mode(MODE_FORWARD);
      add_random_rows(100);
      add_item(16'($urandom), 16'($urandom), 1'b0);
      settle();

      write_mode(MODE_BACKWARD);
      add_random_rows(50);
      settle();

      if (mismatches == 0 && pool_results_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
design/rpmp_pkg.sv
design/rpmp_front.sv
design/rpmp_queue.sv
design/rpmp_back.sv
design/row_prefix_max_pool_unit.sv
design/rpmp_checker.sv
sim/row_prefix_max_pool_unit_test.sv
